[hw/rtl/xcpd_pkg.sv]
// Shared types and constants for the XOR-checked packet deframer.
package xcpd_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int LEN_WIDTH    = 16;
   localparam int STATUS_WIDTH = 2;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PACKET_VERSION = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_PAYLOAD    = 2'd1;

   // Register reset values
   localparam logic [BYTE_WIDTH-1:0] PACKET_VERSION_RESET = 8'd1;
   localparam logic [LEN_WIDTH-1:0]  MAX_PAYLOAD_RESET    = 16'd128;

   // Frame end status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_VERSION = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_LONG    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_CHECK   = 2'd3;

   // Receive phase, one-hot
   typedef enum logic [5:0] {
      PH_VERSION = 6'b000001,
      PH_ID      = 6'b000010,
      PH_LEN_HI  = 6'b000100,
      PH_LEN_LO  = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_CHECK   = 6'b100000
   } phase_type;

endpackage

[hw/rtl/xcpd_channels_if.sv]
// Valid/ready channel interfaces for the deframer's input, result and CSR ports.
interface xcpd_req_if;
   logic                            valid;
   logic                            ready;
   logic [xcpd_pkg::BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcpd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              is_end;
   logic [xcpd_pkg::BYTE_WIDTH-1:0]   data_byte;
   logic [xcpd_pkg::BYTE_WIDTH-1:0]   packet_id;
   logic [xcpd_pkg::LEN_WIDTH-1:0]    payload_length;
   logic [xcpd_pkg::STATUS_WIDTH-1:0] status;

   modport source (output valid, output is_end, output data_byte, output packet_id,
                   output payload_length, output status, input ready);
   modport sink   (input valid, input is_end, input data_byte, input packet_id,
                   input payload_length, input status, output ready);
endinterface

interface xcpd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [xcpd_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [xcpd_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/xor_checked_packet_deframer_top.sv]
// Top level of the XOR-checked, length-prefixed packet deframer.
//
// Usage:
//   req_if  : one received byte per transaction (rx_byte).
//   rsp_if  : payload bytes (is_end = 0) and one end-of-frame status
//             transaction per frame (is_end = 1, status 0 ok, 1 bad version,
//             2 too long, 3 checksum mismatch).
//   csr_if  : register writes; index 0 = expected version byte,
//             index 1 = largest accepted payload length. Always ready.
// Header errors are reported on the fourth header byte; the block then waits
// for the next version byte.
// Throughput: one byte per cycle. Latency: a result is on rsp_if the cycle
// after its byte is accepted. The frame state and one result register set the
// figure: the whole per-byte step (compare, counter, XOR) sits between them.
// Stall: req_if.ready follows "result register empty or being taken", so the
// block keeps taking bytes while rsp_if drains and holds when it stalls.
// Reset (synchronous, active high): registers return to version 1 and
// maximum payload 128, the block waits for a version byte, rsp_if is empty.
module xor_checked_packet_deframer_top (
   input logic        clock,
   input logic        reset,
   xcpd_csr_if.sink   csr_if,
   xcpd_req_if.sink   req_if,
   xcpd_rsp_if.source rsp_if
);

   // Configuration registers
   logic [xcpd_pkg::BYTE_WIDTH-1:0] packet_version_ff;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  max_payload_ff;

   // Frame state
   xcpd_pkg::phase_type             phase_ff, phase_in;
   logic                            version_good_ff, version_good_in;
   logic [xcpd_pkg::BYTE_WIDTH-1:0] frame_id_ff, frame_id_in;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  decl_len_ff, decl_len_in;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  bytes_left_ff, bytes_left_in;
   logic [xcpd_pkg::BYTE_WIDTH-1:0] run_xor_ff, run_xor_in;

   // Result register
   logic                              rsp_valid_ff;
   logic                              rsp_is_end_ff, rsp_is_end_in;
   logic [xcpd_pkg::BYTE_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic [xcpd_pkg::STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [xcpd_pkg::BYTE_WIDTH-1:0]   rsp_id_ff;
   logic [xcpd_pkg::LEN_WIDTH-1:0]    rsp_len_ff;
   logic                              emit;

   logic                            req_fire;
   logic                            rsp_fire;
   logic [xcpd_pkg::BYTE_WIDTH-1:0] rx;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  bytes_dec;

   assign csr_if.ready = 1'b1;
   assign rsp_fire     = rsp_valid_ff && rsp_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign rx           = req_if.rx_byte;
   assign bytes_dec    = bytes_left_ff - 16'd1;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         packet_version_ff <= xcpd_pkg::PACKET_VERSION_RESET;
         max_payload_ff    <= xcpd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            xcpd_pkg::REG_PACKET_VERSION: begin
               packet_version_ff <= csr_if.data[xcpd_pkg::BYTE_WIDTH-1:0];
            end
            xcpd_pkg::REG_MAX_PAYLOAD: begin
               max_payload_ff <= csr_if.data;
            end
            default: begin
            end
         endcase
      end
   end

   // Per-byte frame step
   always_comb begin
      phase_in        = phase_ff;
      version_good_in = version_good_ff;
      frame_id_in     = frame_id_ff;
      decl_len_in     = decl_len_ff;
      bytes_left_in   = bytes_left_ff;
      run_xor_in      = run_xor_ff ^ rx;
      emit            = 1'b0;
      rsp_is_end_in   = 1'b1;
      rsp_data_in     = '0;
      rsp_status_in   = xcpd_pkg::STATUS_OK;
      unique case (phase_ff)
         xcpd_pkg::PH_ID: begin
            frame_id_in = rx;
            phase_in    = xcpd_pkg::PH_LEN_HI;
         end
         xcpd_pkg::PH_LEN_HI: begin
            decl_len_in = {rx, 8'h00};
            phase_in    = xcpd_pkg::PH_LEN_LO;
         end
         xcpd_pkg::PH_LEN_LO: begin
            decl_len_in = {decl_len_ff[15:8], rx};
            if (!version_good_ff) begin
               emit          = 1'b1;
               rsp_status_in = xcpd_pkg::STATUS_BAD_VERSION;
               phase_in      = xcpd_pkg::PH_VERSION;
            end else if (decl_len_in > max_payload_ff) begin
               emit          = 1'b1;
               rsp_status_in = xcpd_pkg::STATUS_TOO_LONG;
               phase_in      = xcpd_pkg::PH_VERSION;
            end else begin
               bytes_left_in = decl_len_in;
               phase_in      = (decl_len_in == '0) ? xcpd_pkg::PH_CHECK
                                                   : xcpd_pkg::PH_PAYLOAD;
            end
         end
         xcpd_pkg::PH_PAYLOAD: begin
            bytes_left_in = bytes_dec;
            emit          = 1'b1;
            rsp_is_end_in = 1'b0;
            rsp_data_in   = rx;
            if (bytes_dec == '0) begin
               phase_in = xcpd_pkg::PH_CHECK;
            end
         end
         xcpd_pkg::PH_CHECK: begin
            emit          = 1'b1;
            rsp_status_in = (rx == run_xor_ff) ? xcpd_pkg::STATUS_OK
                                               : xcpd_pkg::STATUS_BAD_CHECK;
            phase_in      = xcpd_pkg::PH_VERSION;
         end
         default: begin
            // Version byte; unused phase codes land here too
            version_good_in = (rx == packet_version_ff);
            run_xor_in      = rx;
            phase_in        = xcpd_pkg::PH_ID;
         end
      endcase
   end

   // Advance frame state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= xcpd_pkg::PH_VERSION;
         version_good_ff <= 1'b0;
         frame_id_ff     <= '0;
         decl_len_ff     <= '0;
         bytes_left_ff   <= '0;
         run_xor_ff      <= '0;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         version_good_ff <= version_good_in;
         frame_id_ff     <= frame_id_in;
         decl_len_ff     <= decl_len_in;
         bytes_left_ff   <= bytes_left_in;
         run_xor_ff      <= run_xor_in;
      end
   end

   // Hold or replace the result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_is_end_ff <= rsp_is_end_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= frame_id_in;
         rsp_len_ff    <= decl_len_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.is_end         = rsp_is_end_ff;
   assign rsp_if.data_byte      = rsp_data_ff;
   assign rsp_if.packet_id      = rsp_id_ff;
   assign rsp_if.payload_length = rsp_len_ff;
   assign rsp_if.status         = rsp_status_ff;

   // Phase register stays one-hot
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register lost one-hot encoding");

   // A payload byte is only taken while bytes remain
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == xcpd_pkg::PH_PAYLOAD) |-> (bytes_left_ff != '0))
      else $error("payload byte taken with zero bytes left");

   // The checksum byte always yields an end-of-frame transaction
   a_check_ends: assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == xcpd_pkg::PH_CHECK) |=> rsp_valid_ff && rsp_is_end_ff)
      else $error("checksum byte did not produce a frame end");

   // A frame with a wrong version byte is always reported as bad version at its fourth header byte
   a_bad_version: assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == xcpd_pkg::PH_LEN_LO) && !version_good_ff
      |=> rsp_valid_ff && (rsp_status_ff == xcpd_pkg::STATUS_BAD_VERSION))
      else $error("bad version not reported at fourth header byte");

endmodule

[tb/xor_checked_packet_deframer_top_test.sv]
// Self-checking testbench for the XOR-checked packet deframer top level.
module xor_checked_packet_deframer_top_test;

   // Configuration indexes with no register behind them
   localparam logic [xcpd_pkg::CSR_IDX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [xcpd_pkg::CSR_IDX_WIDTH-1:0] REG_SPARE_HI = 2'd3;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic                              is_end;
      logic [xcpd_pkg::BYTE_WIDTH-1:0]   data_byte;
      logic [xcpd_pkg::BYTE_WIDTH-1:0]   packet_id;
      logic [xcpd_pkg::LEN_WIDTH-1:0]    payload_length;
      logic [xcpd_pkg::STATUS_WIDTH-1:0] status;
   } frame_out_type;

   typedef struct {
      logic [xcpd_pkg::BYTE_WIDTH-1:0] value;
      bit                              hold;
   } rx_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xcpd_csr_if csr_ch();
   xcpd_req_if req_ch();
   xcpd_rsp_if rsp_ch();

   xor_checked_packet_deframer_top dut (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_ch),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #2 clock = ~clock;

   // Bytes waiting to be sent and outputs waiting to arrive
   rx_item_type   rx_stream[$];
   frame_out_type deframed_due[$];
   int            error_count = 0;

   // Register copies and receive state of the prediction
   logic [xcpd_pkg::BYTE_WIDTH-1:0] cfg_version = xcpd_pkg::PACKET_VERSION_RESET;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  cfg_max     = xcpd_pkg::MAX_PAYLOAD_RESET;
   xcpd_pkg::phase_type             rx_phase    = xcpd_pkg::PH_VERSION;
   logic                            ver_ok      = 1'b0;
   logic [xcpd_pkg::BYTE_WIDTH-1:0] cur_id      = '0;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  cur_len     = '0;
   logic [xcpd_pkg::LEN_WIDTH-1:0]  remaining   = '0;
   logic [xcpd_pkg::BYTE_WIDTH-1:0] xor_acc     = '0;

   function automatic frame_out_type frame_end(
      input logic [xcpd_pkg::STATUS_WIDTH-1:0] st);
      frame_out_type r;
      r = '{1'b1, 8'h00, cur_id, cur_len, st};
      return r;
   endfunction

   // Advance the frame parser by one byte and queue the output it causes
   function automatic void deframe_step(input logic [xcpd_pkg::BYTE_WIDTH-1:0] b);
      frame_out_type r;
      case (rx_phase)
         xcpd_pkg::PH_ID: begin
            cur_id = b;
            xor_acc ^= b;
            rx_phase = xcpd_pkg::PH_LEN_HI;
         end
         xcpd_pkg::PH_LEN_HI: begin
            cur_len = {b, 8'h00};
            xor_acc ^= b;
            rx_phase = xcpd_pkg::PH_LEN_LO;
         end
         xcpd_pkg::PH_LEN_LO: begin
            cur_len[7:0] = b;
            xor_acc ^= b;
            // bad version takes priority over an oversized length
            if (!ver_ok) begin
               rx_phase = xcpd_pkg::PH_VERSION;
               deframed_due.push_back(frame_end(xcpd_pkg::STATUS_BAD_VERSION));
            end else if (cur_len > cfg_max) begin
               rx_phase = xcpd_pkg::PH_VERSION;
               deframed_due.push_back(frame_end(xcpd_pkg::STATUS_TOO_LONG));
            end else begin
               remaining = cur_len;
               rx_phase = (cur_len == 0) ? xcpd_pkg::PH_CHECK : xcpd_pkg::PH_PAYLOAD;
            end
         end
         xcpd_pkg::PH_PAYLOAD: begin
            xor_acc ^= b;
            remaining = remaining - 1'b1;
            if (remaining == 0)
               rx_phase = xcpd_pkg::PH_CHECK;
            r = '{1'b0, b, cur_id, cur_len, xcpd_pkg::STATUS_OK};
            deframed_due.push_back(r);
         end
         xcpd_pkg::PH_CHECK: begin
            rx_phase = xcpd_pkg::PH_VERSION;
            deframed_due.push_back(frame_end((b == xor_acc) ? xcpd_pkg::STATUS_OK
                                                            : xcpd_pkg::STATUS_BAD_CHECK));
         end
         default: begin
            ver_ok = (b == cfg_version);
            xor_acc = b;
            rx_phase = xcpd_pkg::PH_ID;
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string what);
      error_count++;
      if (error_count <= 10)
         $display("MISMATCH @%0t: %s", $time, what);
   endfunction

   // Byte driver: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_rx
      rx_item_type item;
      bit          send;
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // predict on the transaction taken at this edge
         if (req_ch.valid)
            deframe_step(req_ch.rx_byte);
         send = 1'b0;
         if (gap_left > 0)
            gap_left--;
         else if (rx_stream.size() != 0 && !(rx_stream[0].hold && deframed_due.size() != 0))
            send = 1'b1;
         if (send) begin
            item = rx_stream.pop_front();
            req_ch.rx_byte <= item.value;
            if (burst_left == 0)
               burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
         req_ch.valid <= send;
      end
   end

   // Result monitor with its own rotating stall pattern
   logic [5:0] stall_tick = '0;
   logic [7:0] stall_mask = 8'hFF;

   always @(posedge clock) begin : watch_rsp
      frame_out_type got;
      frame_out_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.is_end, rsp_ch.data_byte, rsp_ch.packet_id,
                    rsp_ch.payload_length, rsp_ch.status};
            if (deframed_due.size() == 0) begin
               note_mismatch($sformatf(
                  "unexpected output end=%0b data=%02h id=%02h len=%04h st=%0d",
                  got.is_end, got.data_byte, got.packet_id, got.payload_length,
                  got.status));
            end else begin
               want = deframed_due.pop_front();
               if (got.is_end !== want.is_end || got.data_byte !== want.data_byte ||
                   got.packet_id !== want.packet_id ||
                   got.payload_length !== want.payload_length || got.status !== want.status)
                  note_mismatch($sformatf(
                     {"exp end=%0b data=%02h id=%02h len=%04h st=%0d, ",
                      "got end=%0b data=%02h id=%02h len=%04h st=%0d"},
                     want.is_end, want.data_byte, want.packet_id, want.payload_length,
                     want.status, got.is_end, got.data_byte, got.packet_id,
                     got.payload_length, got.status));
            end
         end
         // redraw the stall mask each time the 6-bit tick wraps, often fully open
         stall_tick <= stall_tick + 1'b1;
         if (stall_tick == 0)
            stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         rsp_ch.ready <= stall_mask[stall_tick[2:0]];
      end
   end

   // Append one frame: header, body_count payload bytes, optional checksum
   task automatic queue_frame(input logic [xcpd_pkg::BYTE_WIDTH-1:0] ver,
                              input logic [xcpd_pkg::BYTE_WIDTH-1:0] id,
                              input logic [xcpd_pkg::LEN_WIDTH-1:0] len,
                              input int body_count,
                              input bit with_check, input bit corrupt, input bit hold);
      logic [xcpd_pkg::BYTE_WIDTH-1:0] sum;
      logic [xcpd_pkg::BYTE_WIDTH-1:0] b;
      sum = ver ^ id ^ len[15:8] ^ len[7:0];
      rx_stream.push_back('{ver, hold});
      rx_stream.push_back('{id, 1'b0});
      rx_stream.push_back('{len[15:8], 1'b0});
      rx_stream.push_back('{len[7:0], 1'b0});
      for (int i = 0; i < body_count; i++) begin
         b = 8'($urandom);
         sum ^= b;
         rx_stream.push_back('{b, 1'b0});
      end
      if (with_check) begin
         if (corrupt)
            sum ^= 8'($urandom_range(1, 255));
         rx_stream.push_back('{sum, 1'b0});
      end
   endtask

   // Append a random mix of frames, mostly well formed, until target bytes are queued
   task automatic queue_random_traffic(input int target);
      int                              start;
      int                              kind;
      int                              lim;
      int                              body;
      bit                              hold;
      bit                              noisy;
      logic [xcpd_pkg::LEN_WIDTH-1:0]  len;
      logic [xcpd_pkg::BYTE_WIDTH-1:0] id;
      start = rx_stream.size();
      noisy = (cfg_max <= 255);
      while (rx_stream.size() - start < target) begin
         kind = $urandom_range(0, 99);
         lim  = ($urandom_range(0, 9) == 0) ? 40 : 8;
         if (lim > cfg_max)
            lim = cfg_max;
         hold = ($urandom_range(0, 19) == 0);
         id   = 8'($urandom);
         len  = 16'($urandom_range(0, lim));
         if (kind < 60) begin
            queue_frame(cfg_version, id, len, len, 1'b1, 1'b0, hold);
         end else if (kind < 72) begin
            queue_frame(cfg_version, id, len, len, 1'b1, 1'b1, hold);
         end else if (kind < 82) begin
            queue_frame(cfg_version ^ 8'($urandom_range(1, 255)), id, 16'($urandom),
                        0, 1'b0, 1'b0, hold);
         end else if (kind < 90 && cfg_max != 16'hFFFF) begin
            len = 16'($urandom_range(int'(cfg_max) + 1, 65535));
            queue_frame(cfg_version, id, len, 0, 1'b0, 1'b0, hold);
         end else if (kind < 95 && noisy && lim > 0) begin
            // cut a frame short and let the next one land mid-frame
            len  = 16'($urandom_range(1, lim));
            body = $urandom_range(0, int'(len) - 1);
            queue_frame(cfg_version, id, len, body, 1'b0, 1'b0, hold);
         end else if (kind >= 95 && noisy) begin
            repeat ($urandom_range(1, 4))
               rx_stream.push_back('{8'($urandom), 1'b0});
         end else begin
            queue_frame(cfg_version, id, len, len, 1'b1, 1'b0, hold);
         end
      end
   endtask

   // Write one register and update the predicted copy on acceptance
   task automatic write_reg(input logic [xcpd_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [xcpd_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         xcpd_pkg::REG_PACKET_VERSION: cfg_version = value[xcpd_pkg::BYTE_WIDTH-1:0];
         xcpd_pkg::REG_MAX_PAYLOAD:    cfg_max = value;
         default: ;
      endcase
   endtask

   // Wait for all bytes to go out and all outputs to arrive, then settle
   task automatic drain();
      @(posedge clock);
      while (rx_stream.size() != 0 || req_ch.valid || deframed_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : run_test
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = xcpd_pkg::REG_PACKET_VERSION;
      csr_ch.data    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty payload, extremes, bad checksum with a pause, header errors
      queue_frame(8'h01, 8'hFF, 16'd0, 0, 1'b1, 1'b0, 1'b0);
      queue_frame(8'h01, 8'h00, 16'd3, 3, 1'b1, 1'b0, 1'b0);
      queue_frame(8'h01, 8'h3C, 16'd1, 1, 1'b1, 1'b1, 1'b1);
      queue_frame(8'hFF, 8'h5A, 16'hFFFF, 0, 1'b0, 1'b0, 1'b0);
      queue_frame(8'h01, 8'hC3, 16'd129, 0, 1'b0, 1'b0, 1'b0);
      queue_random_traffic(60);
      drain();

      // low extremes; spare indexes must be ignored
      write_reg(xcpd_pkg::REG_PACKET_VERSION, {8'($urandom), 8'h00});
      write_reg(xcpd_pkg::REG_MAX_PAYLOAD, 16'h0000);
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
      queue_random_traffic(60);
      drain();

      // high extremes, including one frame whose length uses both bytes
      write_reg(xcpd_pkg::REG_PACKET_VERSION, {8'($urandom), 8'hFF});
      write_reg(xcpd_pkg::REG_MAX_PAYLOAD, 16'hFFFF);
      queue_frame(8'hFF, 8'($urandom), 16'd260, 260, 1'b1, 1'b0, 1'b1);
      queue_random_traffic(50);
      drain();

      write_reg(xcpd_pkg::REG_PACKET_VERSION, 16'($urandom));
      write_reg(xcpd_pkg::REG_MAX_PAYLOAD, 16'($urandom_range(1, 40)));
      queue_random_traffic(60);
      drain();

      write_reg(xcpd_pkg::REG_PACKET_VERSION, 16'($urandom));
      write_reg(xcpd_pkg::REG_MAX_PAYLOAD, 16'd16);
      queue_random_traffic(60);
      drain();

      if (error_count == 0)
         $display("xor_checked_packet_deframer_top verification clean");
      else
         $display("xor_checked_packet_deframer_top verification failed");
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin : watchdog
      #(4 * 3_000_000);
      $display("xor_checked_packet_deframer_top verification failed");
      $finish;
   end

endmodule
